### hw/rtl/hpspt_pkg.sv
// shared types and constants for the hall pair shaft position tracker
package hpspt_pkg;

    // widths fixed by the port list
    localparam int CFG_WIDTH     = 16;
    localparam int IN_TIME_WIDTH = 32;
    localparam int OUT_POS_WIDTH = 32;
    localparam int PCT_WIDTH     = 7;
    localparam int QUOT_BITS     = 7;
    localparam int QCNT_WIDTH    = 3;

    localparam logic [PCT_WIDTH-1:0] PCT_FULL      = 7'd100;
    localparam logic [PCT_WIDTH-1:0] PCT_ZERO      = 7'd0;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd100;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_CW      = 2'd1,
        DIR_CCW     = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_A    = 2'd1,
        EDGE_B    = 2'd2
    } t_edge;

    // one hall edge handed to the pairing unit
    typedef struct packed {
        logic step;
        logic is_b;
    } t_pair_cmd;

endpackage

### hw/rtl/hpspt_pair.sv
// hall edge pairing: pending edge, timeout check, position and direction
module hpspt_pair #(
    parameter int POS_WIDTH  = 32,
    parameter int TIME_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hpspt_pkg::t_pair_cmd                i_cmd,
    input  logic [TIME_WIDTH-1:0]               i_now,
    input  logic [hpspt_pkg::CFG_WIDTH-1:0]     i_timeout,
    output logic [POS_WIDTH-1:0]                o_position,
    output hpspt_pkg::t_dir                     o_direction
);

    logic [POS_WIDTH-1:0]  r_pos;
    hpspt_pkg::t_dir       r_dir;
    hpspt_pkg::t_edge      r_pend;
    logic [TIME_WIDTH-1:0] r_pend_time;

    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_in_time;
    hpspt_pkg::t_edge      w_other;
    logic                  w_pair;

    // elapsed time wraps modulo the timestamp width
    assign w_elapsed = i_now - r_pend_time;
    assign w_in_time = (w_elapsed <= TIME_WIDTH'(i_timeout));
    assign w_other   = i_cmd.is_b ? hpspt_pkg::EDGE_A : hpspt_pkg::EDGE_B;
    assign w_pair    = (r_pend == w_other) && w_in_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_dir       <= hpspt_pkg::DIR_UNKNOWN;
            r_pend      <= hpspt_pkg::EDGE_NONE;
            r_pend_time <= '0;
        end else if (i_cmd.step) begin
            if (w_pair) begin
                if (i_cmd.is_b) begin
                    r_pos <= r_pos + POS_WIDTH'(1);
                    r_dir <= hpspt_pkg::DIR_CCW;
                end else begin
                    r_pos <= r_pos - POS_WIDTH'(1);
                    r_dir <= hpspt_pkg::DIR_CW;
                end
                r_pend <= hpspt_pkg::EDGE_NONE;
            end else begin
                r_pend      <= i_cmd.is_b ? hpspt_pkg::EDGE_B : hpspt_pkg::EDGE_A;
                r_pend_time <= i_now;
            end
        end
    end

    assign o_position  = r_pos;
    assign o_direction = r_dir;

endmodule

### hw/rtl/hpspt_div.sv
// restoring divider, one quotient bit per cycle, for the percent scaling
module hpspt_div #(
    parameter int NUM_WIDTH = 40,
    parameter int DEN_WIDTH = 33
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [NUM_WIDTH-1:0]                i_num,
    input  logic [DEN_WIDTH-1:0]                i_den,
    output logic [hpspt_pkg::QUOT_BITS-1:0]     o_quot,
    output logic                                o_done
);

    logic [NUM_WIDTH-1:0]             r_rem;
    logic [DEN_WIDTH-1:0]             r_den;
    logic [hpspt_pkg::QUOT_BITS-1:0]  r_quot;
    logic [hpspt_pkg::QCNT_WIDTH-1:0] r_cnt;
    logic                             r_busy;
    logic                             r_done;

    logic [NUM_WIDTH-1:0] w_shift;
    logic [NUM_WIDTH:0]   w_trial;
    logic                 w_borrow;

    // divisor aligned to the current quotient bit
    assign w_shift  = NUM_WIDTH'(r_den) << r_cnt;
    assign w_trial  = (NUM_WIDTH + 1)'(r_rem) - (NUM_WIDTH + 1)'(w_shift);
    assign w_borrow = w_trial[NUM_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= hpspt_pkg::QCNT_WIDTH'(hpspt_pkg::QUOT_BITS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_borrow) begin
                    r_rem <= w_trial[NUM_WIDTH-1:0];
                end
                r_quot[r_cnt] <= !w_borrow;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - hpspt_pkg::QCNT_WIDTH'(1);
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

### hw/rtl/hall_pair_shaft_position_tracker_unit.sv
// top level of the hall pair shaft position tracker
//
// input channel (i_valid / o_ready): one event per transaction, either a
// hall interrupt (i_op low, i_line_a / i_line_b flag the edges seen) or a
// calibration press (i_op high, i_line_a captures the minimum, i_line_b
// the maximum), stamped with the free-running millisecond time i_now_ms
// output channel (o_valid / i_ready): one result per event, the wrapped
// signed position, the last direction and the position as a percent of the
// calibrated span (clamped to 0..100, zero when the span is not positive)
// config channel (i_cfg_valid / o_cfg_ready): writes the pair timeout in
// milliseconds; always ready, only to be written while the block is idle
// sequence: the sequencer walks one event through A edge, B edge, span,
// clamp, an iterative divider giving one quotient bit a cycle, and a final
// step that loads the output register; a clamped event skips the divider
// one event in work at a time, o_ready high only when idle
// a stalled receiver keeps the result in the output register while the
// next event is accepted and worked; that event then waits at its end
// until the output register is free
// reset (synchronous, active low): position, direction, pending edge and
// calibration points go to zero, timeout to 100 ms, no result pending
module hall_pair_shaft_position_tracker_unit #(
    parameter int POS_WIDTH  = 32,
    parameter int TIME_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // event channel
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic                                      i_op,
    input  logic                                      i_line_a,
    input  logic                                      i_line_b,
    input  logic [hpspt_pkg::IN_TIME_WIDTH-1:0]       i_now_ms,
    // result channel
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic signed [hpspt_pkg::OUT_POS_WIDTH-1:0] o_position,
    output logic [hpspt_pkg::PCT_WIDTH-1:0]           o_percent,
    output logic [1:0]                                o_direction,
    // timeout register write
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [hpspt_pkg::CFG_WIDTH-1:0]           i_cfg_data
);

    // differences one bit wider than the position, numerator holds x100
    localparam int DIFF_WIDTH = POS_WIDTH + 1;
    localparam int NUM_WIDTH  = DIFF_WIDTH + hpspt_pkg::QUOT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_SPAN,
        S_CLAMP,
        S_DIV,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic [hpspt_pkg::CFG_WIDTH-1:0]  r_timeout;
    logic                             r_op;
    logic                             r_a;
    logic                             r_b;
    logic [TIME_WIDTH-1:0]            r_now;
    logic [POS_WIDTH-1:0]             r_cal_lo;
    logic [POS_WIDTH-1:0]             r_cal_hi;
    logic signed [DIFF_WIDTH-1:0]     r_diff;
    logic signed [DIFF_WIDTH-1:0]     r_span;
    logic [hpspt_pkg::PCT_WIDTH-1:0]  r_pct;
    logic                             r_o_valid;
    logic signed [hpspt_pkg::OUT_POS_WIDTH-1:0] r_o_position;
    logic [hpspt_pkg::PCT_WIDTH-1:0]  r_o_percent;
    hpspt_pkg::t_dir                  r_o_direction;

    hpspt_pkg::t_pair_cmd             w_pair_cmd;
    logic [POS_WIDTH-1:0]             w_pos;
    hpspt_pkg::t_dir                  w_dir;
    logic signed [DIFF_WIDTH-1:0]     w_diff;
    logic signed [DIFF_WIDTH-1:0]     w_span;
    logic [NUM_WIDTH-1:0]             w_num;
    logic                             w_div_start;
    logic [hpspt_pkg::QUOT_BITS-1:0]  w_quot;
    logic                             w_div_done;
    logic                             w_out_free;

    // edge a is handled in its own cycle, edge b in the next
    assign w_pair_cmd.step = !r_op && (((r_state == S_EDGE_A) && r_a) ||
                                       ((r_state == S_EDGE_B) && r_b));
    assign w_pair_cmd.is_b = (r_state == S_EDGE_B);

    hpspt_pair #(
        .POS_WIDTH  (POS_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_pair (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pair_cmd),
        .i_now       (r_now),
        .i_timeout   (r_timeout),
        .o_position  (w_pos),
        .o_direction (w_dir)
    );

    // signed differences at one extra bit, no overflow
    assign w_diff = DIFF_WIDTH'($signed(w_pos)) - DIFF_WIDTH'($signed(r_cal_lo));
    assign w_span = DIFF_WIDTH'($signed(r_cal_hi)) - DIFF_WIDTH'($signed(r_cal_lo));

    // only reached with 0 <= diff < span, so the quotient stays below 100
    assign w_num = $unsigned(NUM_WIDTH'(r_diff)) * NUM_WIDTH'(hpspt_pkg::PCT_FULL);

    assign w_div_start = (r_state == S_CLAMP) && (r_span > 0) && (r_diff >= 0) &&
                         (r_diff < r_span);

    hpspt_div #(
        .NUM_WIDTH (NUM_WIDTH),
        .DEN_WIDTH (DIFF_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   ($unsigned(r_span)),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // output register can take a new result this cycle
    assign w_out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= hpspt_pkg::TIMEOUT_RESET;
            r_cal_lo  <= '0;
            r_cal_hi  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            // the final step reloads the output register itself
            if (r_o_valid && i_ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_op;
                        r_a     <= i_line_a;
                        r_b     <= i_line_b;
                        r_now   <= TIME_WIDTH'(i_now_ms);
                        r_state <= S_EDGE_A;
                    end
                end
                S_EDGE_A: begin
                    // calibration capture, position is not touched by a press
                    if (r_op) begin
                        if (r_a) begin
                            r_cal_lo <= w_pos;
                        end
                        if (r_b) begin
                            r_cal_hi <= w_pos;
                        end
                    end
                    r_state <= S_EDGE_B;
                end
                S_EDGE_B: begin
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_diff  <= w_diff;
                    r_span  <= w_span;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        // empty span or below minimum gives zero, at or past max full
                        if ((r_span > 0) && (r_diff >= r_span)) begin
                            r_pct <= hpspt_pkg::PCT_FULL;
                        end else begin
                            r_pct <= hpspt_pkg::PCT_ZERO;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pct   <= w_quot;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid     <= 1'b1;
                        r_o_position  <= hpspt_pkg::OUT_POS_WIDTH'($signed(w_pos));
                        r_o_percent   <= r_pct;
                        r_o_direction <= w_dir;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_position  = r_o_position;
    assign o_percent   = r_o_percent;
    assign o_direction = r_o_direction;

    // a result only appears from the final sequencer step
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final step");

    // the clamp logic and the divider keep the percent within range
    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_percent <= hpspt_pkg::PCT_FULL))
        else $error("percent above full scale");

    // the divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    // an accepted event starts with the a edge step
    a_accept_to_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EDGE_A))
        else $error("accepted event did not start the sequence");

endmodule

### dv/hall_pair_shaft_position_tracker_unit_tb.sv
// self-checking testbench for the hall pair shaft position tracker unit
module hall_pair_shaft_position_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    // watchdog limit, sized for heavy receiver idling
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PRESSURE_HOLD = 400;
    localparam int MAX_REPORTED  = 10;
    localparam int PERCENT_SCALE = 100;

    // one expected result transaction
    typedef struct {
        logic signed [hpspt_pkg::OUT_POS_WIDTH-1:0] position;
        logic [hpspt_pkg::PCT_WIDTH-1:0]            percent;
        hpspt_pkg::t_dir                            direction;
    } t_shaft_report;

    // tracks the shaft state and holds the results still to come
    class t_shaft_position_checker;
        logic [hpspt_pkg::OUT_POS_WIDTH-1:0] pos_count;
        logic [hpspt_pkg::OUT_POS_WIDTH-1:0] cal_lo;
        logic [hpspt_pkg::OUT_POS_WIDTH-1:0] cal_hi;
        logic [hpspt_pkg::IN_TIME_WIDTH-1:0] pend_time;
        logic [hpspt_pkg::CFG_WIDTH-1:0]     timeout;
        hpspt_pkg::t_dir                     last_dir;
        hpspt_pkg::t_edge                    pend_edge;
        t_shaft_report                       expected_reports[$];
        int                                  failures;

        function new();
            pos_count = '0;
            cal_lo    = '0;
            cal_hi    = '0;
            pend_time = '0;
            timeout   = hpspt_pkg::TIMEOUT_RESET;
            last_dir  = hpspt_pkg::DIR_UNKNOWN;
            pend_edge = hpspt_pkg::EDGE_NONE;
            failures  = 0;
        endfunction

        function void set_timeout(logic [hpspt_pkg::CFG_WIDTH-1:0] value);
            timeout = value;
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        // an edge completes a quarter turn if the other sensor is pending in time
        function void apply_edge(hpspt_pkg::t_edge seen,
                                 logic [hpspt_pkg::IN_TIME_WIDTH-1:0] stamp);
            hpspt_pkg::t_edge                    other;
            logic [hpspt_pkg::IN_TIME_WIDTH-1:0] gap;
            other = (seen == hpspt_pkg::EDGE_A) ? hpspt_pkg::EDGE_B : hpspt_pkg::EDGE_A;
            gap   = stamp - pend_time;
            if (pend_edge == other && gap <= hpspt_pkg::IN_TIME_WIDTH'(timeout)) begin
                if (seen == hpspt_pkg::EDGE_B) begin
                    pos_count = pos_count + hpspt_pkg::OUT_POS_WIDTH'(1);
                    last_dir  = hpspt_pkg::DIR_CCW;
                end else begin
                    pos_count = pos_count - hpspt_pkg::OUT_POS_WIDTH'(1);
                    last_dir  = hpspt_pkg::DIR_CW;
                end
                pend_edge = hpspt_pkg::EDGE_NONE;
            end else begin
                pend_edge = seen;
                pend_time = stamp;
            end
        endfunction

        // spans wider than the position, truncating division, clamped
        function logic [hpspt_pkg::PCT_WIDTH-1:0] scaled_percent();
            longint span;
            longint offset;
            longint quot;
            span = longint'($signed(cal_hi)) - longint'($signed(cal_lo));
            if (span <= 0)
                return hpspt_pkg::PCT_ZERO;
            offset = longint'($signed(pos_count)) - longint'($signed(cal_lo));
            quot   = (offset * PERCENT_SCALE) / span;
            if (quot < 0)
                return hpspt_pkg::PCT_ZERO;
            if (quot > PERCENT_SCALE)
                return hpspt_pkg::PCT_FULL;
            return hpspt_pkg::PCT_WIDTH'(quot);
        endfunction

        function void note_event(logic op, logic line_a, logic line_b,
                                 logic [hpspt_pkg::IN_TIME_WIDTH-1:0] stamp);
            t_shaft_report rpt;
            if (!op) begin
                if (line_a)
                    apply_edge(hpspt_pkg::EDGE_A, stamp);
                if (line_b)
                    apply_edge(hpspt_pkg::EDGE_B, stamp);
            end else begin
                if (line_a)
                    cal_lo = pos_count;
                if (line_b)
                    cal_hi = pos_count;
            end
            rpt.position  = pos_count;
            rpt.percent   = scaled_percent();
            rpt.direction = last_dir;
            expected_reports.push_back(rpt);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTED)
                $display("mismatch: %s", msg);
        endfunction

        function void check_report(logic signed [hpspt_pkg::OUT_POS_WIDTH-1:0] position,
                                   logic [hpspt_pkg::PCT_WIDTH-1:0] percent,
                                   logic [1:0] direction);
            t_shaft_report exp_rpt;
            if (expected_reports.size() == 0) begin
                flag($sformatf("result with no event waiting: position %0d percent %0d",
                               position, percent));
                return;
            end
            exp_rpt = expected_reports.pop_front();
            if (position !== exp_rpt.position)
                flag($sformatf("position expected %0d got %0d", exp_rpt.position, position));
            if (percent !== exp_rpt.percent)
                flag($sformatf("percent expected %0d got %0d", exp_rpt.percent, percent));
            if (direction !== exp_rpt.direction)
                flag($sformatf("direction expected %0d got %0d", exp_rpt.direction, direction));
        endfunction
    endclass

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_ready;
    logic                                 i_op        = 1'b0;
    logic                                 i_line_a    = 1'b0;
    logic                                 i_line_b    = 1'b0;
    logic [hpspt_pkg::IN_TIME_WIDTH-1:0]  i_now_ms    = '0;
    logic                                 o_valid;
    logic                                 i_ready     = 1'b0;
    logic signed [hpspt_pkg::OUT_POS_WIDTH-1:0] o_position;
    logic [hpspt_pkg::PCT_WIDTH-1:0]      o_percent;
    logic [1:0]                           o_direction;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [hpspt_pkg::CFG_WIDTH-1:0]      i_cfg_data  = hpspt_pkg::TIMEOUT_RESET;

    t_shaft_position_checker sb = new();

    // idling percentages for each side, and the long receiver hold-off
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_left  = 0;

    // stimulus generator state: running timestamp and next edge of the run
    logic [hpspt_pkg::IN_TIME_WIDTH-1:0] gen_now    = '0;
    logic                                gen_next_a = 1'b1;

    hall_pair_shaft_position_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_line_a    (i_line_a),
        .i_line_b    (i_line_b),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_position  (o_position),
        .o_percent   (o_percent),
        .o_direction (o_direction),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // receiver: a long hold-off when asked for, otherwise random idling
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // every result transaction is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_report(o_position, o_percent, o_direction);
    end

    // watchdog
    initial begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
            @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // offers one event, idling first at random; valid stays up until accepted
    task automatic send_event(input logic op, input logic line_a, input logic line_b,
                              input logic [hpspt_pkg::IN_TIME_WIDTH-1:0] stamp);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_line_a <= line_a;
        i_line_b <= line_b;
        i_now_ms <= stamp;
        do
            @(posedge i_clk);
        while (!o_ready);
        sb.note_event(op, line_a, line_b, stamp);
    endtask

    task automatic stop_events();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // register write, only with nothing in flight
    task automatic write_timeout(input logic [hpspt_pkg::CFG_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        sb.set_timeout(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly clean quarter-turn runs, with button presses and odd edges mixed in
    task automatic run_random(input int count);
        logic op;
        logic line_a;
        logic line_b;
        int   roll;
        int   sel;
        for (int n = 0; n < count; n++) begin
            // time step: mostly within the timeout, some at the boundary, some wild
            roll = $urandom_range(99);
            if (roll < 75)
                gen_now += hpspt_pkg::IN_TIME_WIDTH'($urandom_range(sb.timeout));
            else if (roll < 85)
                gen_now += hpspt_pkg::IN_TIME_WIDTH'(sb.timeout) +
                           hpspt_pkg::IN_TIME_WIDTH'($urandom_range(2));
            else if (roll < 95)
                gen_now = $urandom;
            else
                gen_now = '1 - hpspt_pkg::IN_TIME_WIDTH'($urandom_range(300));

            roll = $urandom_range(99);
            if (roll < 12) begin
                // calibration press: none, min, max or both
                sel    = $urandom_range(3);
                op     = 1'b1;
                line_a = sel[0];
                line_b = sel[1];
            end else if (roll < 20) begin
                sel    = $urandom_range(3);
                op     = 1'b0;
                line_a = sel[0];
                line_b = sel[1];
            end else begin
                // alternate edges; repeating one now and then turns the direction round
                op     = 1'b0;
                line_a = gen_next_a;
                line_b = !gen_next_a;
                if ($urandom_range(99) >= 8)
                    gen_next_a = !gen_next_a;
            end
            send_event(op, line_a, line_b, gen_now);
        end
        stop_events();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 88;

        // directed events under the reset timeout of 100 ms
        send_event(1'b0, 1'b0, 1'b0, 32'h0000_0000);    // no edge at all
        send_event(1'b0, 1'b1, 1'b0, 32'hFFFF_FFF0);    // A pending just before the wrap
        send_event(1'b0, 1'b0, 1'b1, 32'h0000_0010);    // B pairs across the wrap
        send_event(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);    // both edges together
        send_event(1'b0, 1'b0, 1'b1, 32'd1000);
        send_event(1'b0, 1'b1, 1'b0, 32'd1100);         // gap exactly the timeout
        send_event(1'b0, 1'b0, 1'b1, 32'd2000);
        send_event(1'b0, 1'b1, 1'b0, 32'd2101);         // one past, A becomes pending
        send_event(1'b0, 1'b0, 1'b1, 32'd2150);
        send_event(1'b1, 1'b0, 1'b0, 32'd2200);         // press with no button
        send_event(1'b1, 1'b0, 1'b1, 32'd2300);         // maximum at full span
        send_event(1'b0, 1'b0, 1'b1, 32'd2400);
        send_event(1'b0, 1'b1, 1'b0, 32'd2410);         // half way
        send_event(1'b0, 1'b0, 1'b1, 32'd2500);
        send_event(1'b0, 1'b1, 1'b0, 32'd2510);         // at the minimum
        send_event(1'b0, 1'b0, 1'b1, 32'd2600);
        send_event(1'b0, 1'b1, 1'b0, 32'd2610);         // below, clamped to zero
        send_event(1'b1, 1'b1, 1'b1, 32'd2700);         // both buttons, zero span
        send_event(1'b0, 1'b1, 1'b0, 32'd2800);
        send_event(1'b0, 1'b0, 1'b1, 32'd2810);
        send_event(1'b1, 1'b1, 1'b0, 32'd2900);         // minimum above maximum
        send_event(1'b0, 1'b1, 1'b0, 32'd5000);         // A left pending
        send_event(1'b1, 1'b0, 1'b0, 32'h8000_0000);
        send_event(1'b0, 1'b0, 1'b0, 32'hFFFF_FF00);
        send_event(1'b0, 1'b0, 1'b1, 32'd5050);         // stale edge pairs after the wrap
        stop_events();
        wait_drained();

        // zero timeout: only same-millisecond edges pair
        write_timeout(16'd0);
        gen_now = 32'd6000;
        run_random(600);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 23;
        write_timeout(16'hFFFF);
        run_random(600);
        wait_drained();

        // no idling; the receiver holds off first so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeout(16'($urandom_range(1, 3000)));
        rx_hold_left = PRESSURE_HOLD;
        run_random(300);
        wait_drained();

        write_timeout(16'($urandom_range(1, 500)));
        run_random(300);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
